/* design/graphic_vram_access_mapper_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the graphic VRAM access mapper
// Shared property shorthands, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef GRAPHIC_VRAM_ACCESS_MAPPER_UNIT_MACROS_SVH
`define GRAPHIC_VRAM_ACCESS_MAPPER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GVAM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GVAM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gvam_pkg.sv */
// ----------------------------------------------------------------------------
// gvam_pkg
// Types and constants shared by the graphic VRAM access mapper modules.
// ----------------------------------------------------------------------------
package gvam_pkg;

  localparam int unsigned GVAM_WORDS = 262144;
  localparam int unsigned GVAM_IDX_W = $clog2(GVAM_WORDS);
  localparam int unsigned GVAM_QDEPTH = 2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_SCROLL0 = 3'd1;
  localparam logic [2:0] CFG_SCROLL1 = 3'd2;
  localparam logic [2:0] CFG_SCROLL2 = 3'd3;
  localparam logic [2:0] CFG_SCROLL3 = 3'd4;

  // Colour mode codes in bits 1-0 of the mode register.
  localparam logic [1:0] CM_16   = 2'd0;
  localparam logic [1:0] CM_256A = 2'd1;
  localparam logic [1:0] CM_256B = 2'd2;
  localparam logic [1:0] CM_64K  = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [20:0] offset;
    logic [7:0]  write_data;
  } gvam_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       dirty_a_valid;
    logic [9:0] dirty_a_line;
    logic       dirty_b_valid;
    logic [9:0] dirty_b_line;
  } gvam_rsp_t;

  // Classified access, handed from the front end to the back end.
  typedef struct packed {
    logic                  wr;       // mapped write
    logic                  rd;       // mapped read
    logic                  nib;      // nibble access, else byte
    logic [1:0]            pos;      // nibble position of the access in the word
    logic [GVAM_IDX_W-1:0] idx;
    logic [3:0]            mask;     // nibbles written
    logic [15:0]           wdata;
    logic                  da_v;
    logic [9:0]            da_line;
    logic                  db_v;
    logic [9:0]            db_line;
  } gvam_cmd_t;

endpackage

/* design/graphic_vram_access_mapper_unit.sv */
// A request is written into the queue, popped into the back end's current-access
// register as its word is read, and its result is then registered for output.
// The back end takes no new request until it has finished the last one: a read of
// its word, then for a write a masked write back. Reset: control state clears at
// once; the word store is then cleared one word a cycle, during which requests stall (config writes are taken).
// ----------------------------------------------------------------------------
// graphic_vram_access_mapper_unit
// Maps CPU byte reads and writes of graphics memory onto a 16-bit word store
// by colour mode, and reports the display lines a write makes dirty.
// ----------------------------------------------------------------------------
module graphic_vram_access_mapper_unit import gvam_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  gvam_req_t  in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output gvam_rsp_t  out_rsp_o
);

  logic      busy, q_full, q_empty, push, pop;
  gvam_cmd_t push_cmd, pop_cmd;

  gvam_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .busy_i     (busy),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  gvam_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty)
  );

  gvam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (pop_cmd),
    .pop_o       (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* design/gvam_front.sv */
// ----------------------------------------------------------------------------
// gvam_front
// Holds the configuration registers and classifies each request into a word
// access with nibble mask, read selection and dirty line report.
// ----------------------------------------------------------------------------
module gvam_front import gvam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gvam_req_t in_req_i,
  input  logic      busy_i,
  input  logic      q_full_i,
  output logic      push_o,
  output gvam_cmd_t cmd_o
);

  logic [3:0] mode_q;
  logic [9:0] scroll0_q, scroll1_q, scroll2_q, scroll3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      scroll0_q <= '0;
      scroll1_q <= '0;
      scroll2_q <= '0;
      scroll3_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:    mode_q    <= cfg_data_i[3:0];
        CFG_SCROLL0: scroll0_q <= cfg_data_i;
        CFG_SCROLL1: scroll1_q <= cfg_data_i;
        CFG_SCROLL2: scroll2_q <= cfg_data_i;
        CFG_SCROLL3: scroll3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [9:0] pick_scroll(input logic [1:0] sel,
                                             input logic [9:0] s0, input logic [9:0] s1,
                                             input logic [9:0] s2, input logic [9:0] s3);
    logic [9:0] r;
    case (sel)
      2'd0:    r = s0;
      2'd1:    r = s1;
      2'd2:    r = s2;
      default: r = s3;
    endcase
    return r;
  endfunction

  logic [20:0] a;
  logic [7:0]  d;
  logic        mapped, nib, dirty_a, dirty_b;
  logic [1:0]  pos;
  logic [GVAM_IDX_W-1:0] idx;
  logic [9:0]  la, lb, sa, sb;

  assign a = in_req_i.offset;
  assign d = in_req_i.write_data;

  always_comb begin
    mapped  = 1'b0;
    nib     = 1'b0;
    dirty_a = 1'b0;
    dirty_b = 1'b0;
    pos     = 2'd0;
    idx     = a[18:1];
    la      = '0;
    lb      = '0;
    sa      = '0;
    sb      = '0;
    if (mode_q[3]) begin
      // Linear override: stored, but no line is reported.
      mapped = (a[20:19] == 2'b00);
      pos    = {a[0], 1'b0};
    end else begin
      unique case (mode_q[1:0]) inside
        CM_16: begin
          mapped  = !a[0];
          nib     = 1'b1;
          dirty_a = 1'b1;
          if (mode_q[2]) begin
            idx = {a[19:11], a[9:1]};
            pos = {a[20], a[10]};
            la  = a[20:11] - scroll0_q;
          end else begin
            pos = a[20:19];
            sa  = pick_scroll(a[20:19], scroll0_q, scroll1_q, scroll2_q, scroll3_q);
            la  = {1'b0, a[18:10] - sa[8:0]};
          end
        end
        CM_256A, CM_256B: begin
          mapped  = !a[20] && !a[0];
          pos     = {a[19], 1'b0};
          dirty_a = 1'b1;
          dirty_b = 1'b1;
          sa      = pick_scroll({a[19], 1'b0}, scroll0_q, scroll1_q, scroll2_q, scroll3_q);
          sb      = pick_scroll({a[19], 1'b1}, scroll0_q, scroll1_q, scroll2_q, scroll3_q);
          la      = {1'b0, a[18:10] - sa[8:0]};
          lb      = {1'b0, a[18:10] - sb[8:0]};
        end
        CM_64K: begin
          mapped  = (a[20:19] == 2'b00);
          pos     = {a[0], 1'b0};
          dirty_a = 1'b1;
          la      = {1'b0, a[18:10] - scroll0_q[8:0]};
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.wr      = mapped && in_req_i.operation;
    cmd_o.rd      = mapped && !in_req_i.operation;
    cmd_o.nib     = nib;
    cmd_o.pos     = pos;
    cmd_o.idx     = idx;
    cmd_o.mask    = nib ? (4'b0001 << pos) : (pos[1] ? 4'b1100 : 4'b0011);
    cmd_o.wdata   = nib ? {4{d[3:0]}} : {d, d};
    cmd_o.da_v    = cmd_o.wr && dirty_a;
    cmd_o.da_line = cmd_o.da_v ? la : '0;
    cmd_o.db_v    = cmd_o.wr && dirty_b;
    cmd_o.db_line = cmd_o.db_v ? lb : '0;
  end

  assign in_stall_o = busy_i || q_full_i;
  assign push_o     = in_valid_i && !in_stall_o;

endmodule

/* design/gvam_queue.sv */
// ----------------------------------------------------------------------------
// gvam_queue
// Short queue of classified accesses between front end and back end.
// ----------------------------------------------------------------------------
module gvam_queue import gvam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  gvam_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output gvam_cmd_t pop_cmd_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (GVAM_QDEPTH > 1) ? $clog2(GVAM_QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(GVAM_QDEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(GVAM_QDEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(GVAM_QDEPTH - 1);

  gvam_cmd_t entry_q [GVAM_QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o    = (count_q == Depth);
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* design/gvam_back.sv */
// ----------------------------------------------------------------------------
// gvam_back
// Owns the word store: clears it after reset, then runs each access as a
// read followed, for a write, by a masked write back, and holds the result register.
// ----------------------------------------------------------------------------
module gvam_back import gvam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  gvam_cmd_t q_cmd_i,
  output logic      pop_o,
  output logic      busy_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output gvam_rsp_t out_rsp_o
);

  `include "graphic_vram_access_mapper_unit_macros.svh"

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ} b_state_e;

  b_state_e              state_q;
  logic [GVAM_IDX_W-1:0] clr_addr_q;
  gvam_cmd_t             cur_q;
  logic                  out_valid_q;
  gvam_rsp_t             out_rsp_q;
  logic [15:0]           rdata_q;
  logic [15:0]           vram_mem [GVAM_WORDS];

  logic                  pop, out_free, complete, mem_we;
  logic [GVAM_IDX_W-1:0] mem_waddr;
  logic [15:0]           mem_wdata, bit_mask, merged, shifted;
  logic [7:0]            rd_byte;

  assign pop      = (state_q == B_IDLE) && !q_empty_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign complete = (state_q == B_READ) && out_free;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      bit_mask[4*n +: 4] = {4{cur_q.mask[n]}};
    end
  end

  assign merged  = (rdata_q & ~bit_mask) | (cur_q.wdata & bit_mask);
  assign shifted = rdata_q >> {cur_q.pos, 2'b00};
  assign rd_byte = cur_q.rd ? (shifted[7:0] & (cur_q.nib ? 8'h0f : 8'hff)) : 8'h00;

  // One write port, shared by the clearing pass and the write back.
  assign mem_we    = (state_q == B_CLEAR) || (complete && cur_q.wr);
  assign mem_waddr = (state_q == B_CLEAR) ? clr_addr_q : cur_q.idx;
  assign mem_wdata = (state_q == B_CLEAR) ? 16'h0000 : merged;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vram_mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rdata_q <= vram_mem[q_cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !complete) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == '1) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop) begin
            cur_q   <= q_cmd_i;
            state_q <= B_READ;
          end
        end
        B_READ: begin
          if (out_free) begin
            out_valid_q             <= 1'b1;
            out_rsp_q.read_data     <= rd_byte;
            out_rsp_q.dirty_a_valid <= cur_q.da_v;
            out_rsp_q.dirty_a_line  <= cur_q.da_line;
            out_rsp_q.dirty_b_valid <= cur_q.db_v;
            out_rsp_q.dirty_b_line  <= cur_q.db_line;
            state_q                 <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign pop_o       = pop;
  assign busy_o      = (state_q == B_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `GVAM_ASSERT_IMP(a_no_pop_in_clear, state_q == B_CLEAR, !pop, "pop during clearing pass")
  `GVAM_ASSERT_NXT(a_pop_then_read, pop, state_q == B_READ, "popped access not in read state")
  `GVAM_ASSERT_IMP(a_b_needs_a, out_valid_q && out_rsp_q.dirty_b_valid,
                   out_rsp_q.dirty_a_valid, "second dirty line without first")
  `GVAM_ASSERT_IMP(a_write_reads_zero, out_valid_q && out_rsp_q.dirty_a_valid,
                   out_rsp_q.read_data == 8'h00, "write returned read data")

endmodule
